// File: design/cddd_pkg.sv
// ----------------------------------------------------------------------------
// cddd_pkg
// Shared types, constants and calendar functions for the date day
// difference core.
// ----------------------------------------------------------------------------
package cddd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DIFF_W   = 23;
  localparam int SERIAL_W = 24;
  localparam int YY_W     = 15;

  localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_SWITCH    = 14'd1582;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_OCT      = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_MAX      = 4'd12;
  localparam logic [DAY_W-1:0]   GAP_FIRST_DAY  = 5'd5;
  localparam logic [DAY_W-1:0]   GAP_LAST_DAY   = 5'd14;
  localparam logic [DAY_W-1:0]   GREG_FIRST_DAY = 5'd15;

  // Epoch offsets of the day number for each calendar.
  localparam logic [SERIAL_W-1:0] GREG_OFFSET   = 24'd32045;
  localparam logic [SERIAL_W-1:0] JULIAN_OFFSET = 24'd32083;
  localparam logic [YY_W-1:0]     YEAR_SHIFT    = 15'd4800;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x below 2**15.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
  } dates_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     date_invalid;
  } result_t;

  typedef struct packed {
    logic                ok;
    logic [SERIAL_W-1:0] serial;
  } date_info_t;

  // Days before the month, counted in a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    unique case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Length of a month other than February.
  function automatic logic [DAY_W-1:0] plain_month_length(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: design/cddd_date.sv
// ----------------------------------------------------------------------------
// cddd_date
// Checks one calendar date and converts it to its Julian Day Number.
// ----------------------------------------------------------------------------
module cddd_date (
  input  logic [cddd_pkg::YEAR_W-1:0]  year,
  input  logic [cddd_pkg::MONTH_W-1:0] month,
  input  logic [cddd_pkg::DAY_W-1:0]   day,
  output cddd_pkg::date_info_t         info
);
  import cddd_pkg::*;

  logic [26:0]          ymul;
  logic [7:0]           yq100;
  logic [YEAR_W-1:0]    yhund;
  logic                 div4;
  logic                 div100;
  logic                 div400;
  logic                 leap;
  logic [DAY_W-1:0]     mlen;
  logic                 in_gap;
  logic                 greg;
  logic                 early;
  logic [YY_W-1:0]      yy;
  logic [27:0]          yymul;
  logic [8:0]           yyq100;
  logic [SERIAL_W-1:0]  base;
  logic [SERIAL_W-1:0]  serial;

  // Leap rule: divisibility by 100 through a reciprocal multiply.
  assign ymul   = 27'(year) * 27'(DIV100_MUL);
  assign yq100  = ymul[26:DIV100_SHIFT];
  assign yhund  = YEAR_W'(yq100 * 7'd100);
  assign div4   = (year[1:0] == 2'b00);
  assign div100 = (yhund == year);
  assign div400 = div100 && (yq100[1:0] == 2'b00);
  assign leap   = (year <= YEAR_SWITCH) ? div4 : ((div4 && !div100) || div400);

  assign mlen   = (month == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : plain_month_length(month);
  assign in_gap = (year == YEAR_SWITCH) && (month == MONTH_OCT) &&
                  (day >= GAP_FIRST_DAY) && (day <= GAP_LAST_DAY);

  assign greg = (year > YEAR_SWITCH) ||
                ((year == YEAR_SWITCH) &&
                 ((month > MONTH_OCT) || ((month == MONTH_OCT) && (day >= GREG_FIRST_DAY))));

  // January and February count as months of the previous year.
  assign early  = (month <= MONTH_FEB);
  assign yy     = YY_W'(year) + YEAR_SHIFT - YY_W'(early);
  assign yymul  = 28'(yy) * 28'(DIV100_MUL);
  assign yyq100 = yymul[27:DIV100_SHIFT];

  assign base = SERIAL_W'(day) + SERIAL_W'(month_offset(month)) +
                SERIAL_W'(yy) * SERIAL_W'(365) + SERIAL_W'(yy[YY_W-1:2]);

  always_comb begin
    if (greg) begin
      serial = base - SERIAL_W'(yyq100) + SERIAL_W'(yyq100[8:2]) - GREG_OFFSET;
    end else begin
      serial = base - JULIAN_OFFSET;
    end
  end

  always_comb begin
    info.ok = (year != '0) && (year <= YEAR_MAX) &&
              (month != '0) && (month <= MONTH_MAX) &&
              (day != '0) && (day <= mlen) && !in_gap;
    info.serial = serial;
  end

endmodule

// File: design/calendar_date_day_difference_core.sv
// ----------------------------------------------------------------------------
// calendar_date_day_difference_core
// Signed day count between two calendar dates, Julian before the 1582
// reform and Gregorian from 15 October 1582 on.
// ----------------------------------------------------------------------------
// Each transaction on the dates channel carries two dates; one transaction
// on the result channel comes back for it, in order, carrying the serial day
// of the second date minus that of the first (negative when the second is
// earlier). If either date does not exist (year outside 1..9999, month
// outside 1..12, day beyond the month, or 5..14 October 1582), date_invalid
// is set and the difference is zero. The core is a two-register pipeline:
// an input register, then the day-number conversion and subtraction, then
// the result register. It takes one transaction per clock cycle unless back
// pressure on the result side stalls it; a taken transaction moves through
// the input register and then the result register before its result is
// presented. Throughput is set by the single conversion pass, so with
// result_ready held high it sustains one transaction per cycle. Back pressure
// on the result side stalls the pipeline one stage at a time; an empty input
// stage still takes a new transaction while a finished result waits.
// ----------------------------------------------------------------------------
module calendar_date_day_difference_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              dates_valid,
  output logic              dates_ready,
  input  cddd_pkg::dates_t  dates,
  output logic              result_valid,
  input  logic              result_ready,
  output cddd_pkg::result_t result
);
  import cddd_pkg::*;

  logic       stage_valid;
  dates_t     stage_dates;
  logic       result_load;
  date_info_t first_info;
  date_info_t second_info;
  logic [SERIAL_W-1:0] serial_diff;
  result_t    result_next;

  // Advance the input stage into the result register when the result is
  // empty or being taken this cycle.
  assign result_load = stage_valid && (!result_valid || result_ready);
  assign dates_ready = !stage_valid || result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (dates_ready) begin
      stage_valid <= dates_valid;
    end
  end

  // Hold the captured dates until they move on.
  always_ff @(posedge clk) begin
    if (dates_valid && dates_ready) begin
      stage_dates <= dates;
    end
  end

  cddd_date u_first (
    .year  (stage_dates.first_year),
    .month (stage_dates.first_month),
    .day   (stage_dates.first_day),
    .info  (first_info)
  );

  cddd_date u_second (
    .year  (stage_dates.second_year),
    .month (stage_dates.second_month),
    .day   (stage_dates.second_day),
    .info  (second_info)
  );

  // Drop the difference to zero when either date is impossible.
  assign serial_diff = second_info.serial - first_info.serial;

  always_comb begin
    if (first_info.ok && second_info.ok) begin
      result_next.day_difference = serial_diff[DIFF_W-1:0];
      result_next.date_invalid   = 1'b0;
    end else begin
      result_next.day_difference = '0;
      result_next.date_invalid   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

endmodule
